// File: hdl/sha512_pkg.sv
`timescale 1ns / 1ps
// package for the sha-512 / sha-384 engine: payload types, round constants,
// initial values and the register address. no dependencies.
package sha512_pkg;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  valid_bytes;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam logic [1:0] REG_HASH_MODE = 2'd0;

    function automatic logic [63:0] round_k(input logic [6:0] r);
        logic [63:0] k;
        case (r)
            7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] hash_iv(input logic mode, input logic [2:0] i);
        logic [63:0] v;
        case ({mode, i})
            4'd0: v = 64'h6a09e667f3bcc908;  4'd1: v = 64'hbb67ae8584caa73b;
            4'd2: v = 64'h3c6ef372fe94f82b;  4'd3: v = 64'ha54ff53a5f1d36f1;
            4'd4: v = 64'h510e527fade682d1;  4'd5: v = 64'h9b05688c2b3e6c1f;
            4'd6: v = 64'h1f83d9abfb41bd6b;  4'd7: v = 64'h5be0cd19137e2179;
            4'd8: v = 64'hcbbb9d5dc1059ed8;  4'd9: v = 64'h629a292a367cd507;
            4'd10: v = 64'h9159015a3070dd17; 4'd11: v = 64'h152fecd8f70e5939;
            4'd12: v = 64'h67332667ffc00b31; 4'd13: v = 64'h8eb44a8768581511;
            4'd14: v = 64'hdb0c2e0d64f98fa7; 4'd15: v = 64'h47b5481dbefa4fa4;
            default: v = 64'h0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/sha512_sha384_hash_engine_core.sv
`timescale 1ns / 1ps
// top level of the sha-512 / sha-384 engine: intake, padding, round sequencer,
// digest output. depends on sha512_pkg and sha512_round.
// Streaming SHA-512 / SHA-384 engine. Message words are taken one per cycle, while idle,
// into a 16-entry block memory; the 16th word starts a compression that runs one round
// per cycle (a load step, 80 rounds and a chaining update; the first 16 round words are
// read from the block memory, later schedule words come from a 16-word register window
// and are written back), so the input is stalled while a block is compressed.
// A last word inserts padding one word per cycle and one or two compressions; unless stalled,
// the 8 (SHA-512) or 6 (SHA-384) digest words then leave one per cycle through an output
// register. Writing hash_mode restarts the message with the matching initial value.
module sha512_sha384_hash_engine_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  sha512_pkg::t_in_item   i_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output sha512_pkg::t_out_item  o_data
);
    import sha512_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [63:0]  r_blk [16];
    logic [63:0]  r_blk_q;
    logic [3:0]   blk_raddr;
    logic         blk_we;
    logic [3:0]   blk_waddr;
    logic [63:0]  blk_wdata;

    logic [2:0]   r_state;
    logic         r_mode;
    logic [3:0]   r_fill;
    logic [127:0] r_len;
    logic [511:0] r_hash;
    logic [511:0] r_vars;
    logic [6:0]   r_rnd;
    logic         r_padding;   // compression belongs to final padding
    logic         r_pad_more;  // another padded block follows
    logic         r_marker;    // full last word, marker still to be written
    logic [2:0]   r_oidx;
    logic         r_ovalid;
    t_out_item    r_odata;
    logic [63:0]  r_w1, r_w9, r_w14, r_w15;
    logic [511:0] round_out;
    logic [63:0]  sched;

    logic cfg_wr;
    logic acc;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = {31'd0, r_mode};
    assign o_stall = (r_state != ST_IDLE);
    assign acc     = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    // block memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            r_blk[blk_waddr] <= blk_wdata;
        end
        r_blk_q <= r_blk[blk_raddr];
    end

    logic [3:0]  vb;
    logic [63:0] keep, padw;
    always_comb begin
        vb = (i_data.valid_bytes > 4'd8) ? 4'd8 : i_data.valid_bytes;
        keep = (vb == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {vb[3:0], 3'b000});
        padw = (i_data.message_word & keep) |
               ((vb == 4'd8) ? 64'd0 : (64'h8000000000000000 >> {vb[2:0], 3'b000}));
    end

    // round word: the first 16 come straight from memory, later ones from schedule
    assign sched = ({r_w14[18:0], r_w14[63:19]} ^ {r_w14[60:0], r_w14[63:61]}
                   ^ (r_w14 >> 6)) + r_w9 +
                   ({r_w1[0], r_w1[63:1]} ^ {r_w1[7:0], r_w1[63:8]} ^ (r_w1 >> 7)) + r_w15;

    // schedule window kept in registers r_w15 = w[r-16] etc., memory holds history
    logic [63:0] wr;
    assign wr = (r_rnd < 7'd16) ? r_blk_q : sched;

    sha512_round u_round (
        .i_vars (r_vars),
        .i_wk   (wr + round_k(r_rnd)),
        .o_vars (round_out)
    );

    logic [127:0] len_next;
    logic [63:0]  pad_val;
    always_comb begin
        pad_val = 64'd0;
        if (!r_pad_more && r_fill == 4'd14) pad_val = r_len[124:61];
        if (!r_pad_more && r_fill == 4'd15) pad_val = {r_len[60:0], 3'b000};
        if (r_marker) pad_val = 64'h8000000000000000;
    end

    always_comb begin
        blk_we = 1'b0; blk_waddr = r_fill; blk_wdata = padw;
        blk_raddr = r_rnd[3:0];
        if (acc) begin
            blk_we = 1'b1;
            blk_wdata = i_data.last ? padw : i_data.message_word;
        end else if (r_state == ST_PAD) begin
            blk_we = 1'b1;
            blk_wdata = pad_val;
        end else if (r_state == ST_ROUND && r_rnd >= 7'd16) begin
            blk_we = 1'b1;
            blk_waddr = r_rnd[3:0];
            blk_wdata = sched;
        end
        if (r_state == ST_LOAD) blk_raddr = 4'd0;
        else if (r_state == ST_ROUND) blk_raddr = r_rnd[3:0] + 4'd1;
    end
    assign len_next = r_len + {124'd0, (i_data.last ? vb : 4'd8)};

    // the window registers track w[r-15], w[r-7], w[r-2], w[r-16] by shifting
    // a 16-deep register line alongside the memory would be redundant, so the
    // schedule uses a small shift window of 16 words kept here
    logic [63:0] r_win [16];

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROUND) begin
            for (int j = 0; j < 15; j++) r_win[j] <= r_win[j + 1];
            r_win[15] <= wr;
        end
    end
    always_comb begin
        r_w15 = r_win[0];
        r_w1  = r_win[1];
        r_w9  = r_win[9];
        r_w14 = r_win[14];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_mode <= 1'b0; r_fill <= 4'd0; r_len <= '0;
            r_padding <= 1'b0; r_pad_more <= 1'b0; r_marker <= 1'b0; r_ovalid <= 1'b0;
            r_rnd <= '0; r_oidx <= '0;
            for (int j = 0; j < 8; j++) r_hash[511-64*j -: 64] <= hash_iv(1'b0, 3'(j));
        end else begin
            if (r_ovalid && !i_stall && r_state != ST_OUT) r_ovalid <= 1'b0;
            if (cfg_wr && paddr == REG_HASH_MODE) begin
                r_mode <= pwdata[0]; r_fill <= 4'd0; r_len <= '0;
                for (int j = 0; j < 8; j++) r_hash[511-64*j -: 64] <= hash_iv(pwdata[0], 3'(j));
            end
            case (r_state)
                ST_IDLE: if (acc) begin
                    r_len <= len_next;
                    r_fill <= r_fill + 4'd1;
                    if (i_data.last) begin
                        r_padding <= 1'b1;
                        if (vb == 4'd8) begin
                            // full word, pad marker goes in the next slot
                            r_marker <= 1'b1;
                            r_pad_more <= (r_fill >= 4'd13);
                        end else begin
                            r_pad_more <= (r_fill >= 4'd14);
                        end
                        r_state <= (r_fill == 4'd15) ? ST_LOAD : ST_PAD;
                    end else if (r_fill == 4'd15) begin
                        r_padding <= 1'b0;
                        r_state <= ST_LOAD;
                    end
                end
                ST_PAD: begin
                    r_marker <= 1'b0;
                    r_fill <= r_fill + 4'd1;
                    if (r_fill == 4'd15) r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_vars <= r_hash; r_rnd <= '0; r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_vars <= round_out;
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == 7'd79) r_state <= ST_FIN;
                end
                ST_FIN: begin
                    for (int j = 0; j < 8; j++)
                        r_hash[511-64*j -: 64] <= r_hash[511-64*j -: 64] + r_vars[511-64*j -: 64];
                    r_fill <= 4'd0;
                    r_oidx <= '0;
                    if (!r_padding) r_state <= ST_IDLE;
                    else if (r_pad_more) begin r_pad_more <= 1'b0; r_state <= ST_PAD; end
                    else r_state <= ST_OUT;
                end
                ST_OUT: if (!r_ovalid || !i_stall) begin
                    r_ovalid <= 1'b1;
                    r_odata.digest_word <= r_hash[511-64*r_oidx -: 64];
                    r_odata.word_index <= r_oidx;
                    r_odata.last_word <= (r_oidx == (r_mode ? 3'd5 : 3'd7));
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == (r_mode ? 3'd5 : 3'd7)) begin
                        r_state <= ST_IDLE; r_fill <= 4'd0; r_len <= '0; r_padding <= 1'b0;
                        for (int j = 0; j < 8; j++) r_hash[511-64*j -: 64] <= hash_iv(r_mode, 3'(j));
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd == 7'd79) |=> (r_state == ST_FIN))
        else $error("round count overran");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled digest word changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.last_word) |-> (o_data.word_index == (r_mode ? 3'd5 : 3'd7)))
        else $error("last digest word index wrong");
endmodule

// File: hdl/sha512_round.sv
`timescale 1ns / 1ps
// one sha-512 round: working variables a..h and the round word in, next a..h out.
// depends on sha512_pkg.
module sha512_round (
    input  logic [511:0] i_vars,
    input  logic [63:0]  i_wk,
    output logic [511:0] o_vars
);
    import sha512_pkg::*;

    logic [63:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;

    always_comb begin
        {a, b, c, d, e, f, g, h} = i_vars;
        s1 = {e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]};
        s0 = {a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]};
        // i_wk already holds k plus w
        t1 = h + s1 + ((e & f) ^ (~e & g)) + i_wk;
        t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
        o_vars = {t1 + t2, a, b, c, d + t1, e, f, g};
    end
endmodule
